// File: hw/rtl/frg_pkg.sv
package frg_pkg;

   localparam int WORD_BITS_DEFAULT = 64;

   localparam int NUM_BITS = 64;
   localparam int DEN_BITS = 63;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

endpackage

// File: hw/rtl/frg_req_if.sv
interface frg_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [frg_pkg::NUM_BITS-1:0]   numerator;
   logic signed [frg_pkg::NUM_BITS-1:0]   denominator;

   modport source (output valid, output numerator, output denominator, input ready);
   modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

// File: hw/rtl/frg_rsp_if.sv
interface frg_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [frg_pkg::NUM_BITS-1:0]   reduced_numerator;
   logic [frg_pkg::DEN_BITS-1:0]          reduced_denominator;
   frg_pkg::status_type                   status;

   modport source (output valid, output reduced_numerator, output reduced_denominator,
                   output status, input ready);
   modport sink   (input valid, input reduced_numerator, input reduced_denominator,
                   input status, output ready);
endinterface

// File: hw/rtl/fraction_reduce_gcd.sv
// Fraction reduction to lowest terms.
// A request on req_port carries a signed numerator and denominator; the low
// WORD_BITS bits of each are used, bit WORD_BITS-1 being the sign. For every
// request one response leaves on rsp_port: the reduced numerator (sign
// extended to 64 bits), a positive reduced denominator and a status (ok,
// zero denominator, or sign negation overflow; both values are 0 on error).
// One request is worked on at a time; req_port.ready is high only while the
// block is idle. Zero denominator, zero numerator and overflow cases go
// straight to DONE. Otherwise one subtractor does all the work: a binary GCD
// (common twos, then halve or subtract-and-halve), a rescale by the common
// twos, then two restoring divisions. A new request is taken once the block
// is back in idle.
// The finished response sits in an output register; if the receiver stalls
// it holds there, and the next result waits in the block until the output
// register is free; no new request is accepted until it has been handed over.
// Reset (synchronous) returns to idle and drops any response in flight.
module fraction_reduce_gcd #(
   parameter int WORD_BITS = frg_pkg::WORD_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   frg_req_if.sink   req_port,
   frg_rsp_if.source rsp_port
);

   localparam int W        = WORD_BITS;
   localparam int CNT_BITS = $clog2(WORD_BITS);

   typedef enum logic [2:0] {
      IDLE,
      TWOS,
      GCD,
      SCALE,
      DIVN,
      DIVD,
      DONE
   } state_type;

   state_type state_ff, state_in;

   logic [W-1:0]          a_ff, a_in;
   logic [W-1:0]          b_ff, b_in;
   logic [W-1:0]          num_ff, num_in;
   logic [W-1:0]          den_ff, den_in;
   logic [W-1:0]          rem_ff, rem_in;
   logic [W-1:0]          quo_ff, quo_in;
   logic [W-1:0]          nq_ff, nq_in;
   logic [CNT_BITS-1:0]   k_ff, k_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;

   logic signed [frg_pkg::NUM_BITS-1:0] res_num_ff, res_num_in;
   logic [frg_pkg::DEN_BITS-1:0]        res_den_ff, res_den_in;
   frg_pkg::status_type                 res_st_ff, res_st_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [frg_pkg::NUM_BITS-1:0] rsp_num_ff, rsp_num_in;
   logic [frg_pkg::DEN_BITS-1:0]        rsp_den_ff, rsp_den_in;
   frg_pkg::status_type                 rsp_st_ff, rsp_st_in;

   // shared subtractor
   logic [W:0] sub_x, sub_y, sub_diff;
   logic       sub_borrow;

   logic [W-1:0] n_w, d_w, n_mag, d_mag, most_neg, quo_shift, num_signed;
   logic         req_fire, rsp_free;

   assign req_port.ready = (state_ff == IDLE);
   assign req_fire       = req_port.valid && req_port.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_port.ready;

   assign n_w      = req_port.numerator[W-1:0];
   assign d_w      = req_port.denominator[W-1:0];
   assign most_neg = {1'b1, {(W-1){1'b0}}};
   assign n_mag    = n_w[W-1] ? (~n_w + 1'b1) : n_w;
   assign d_mag    = d_w[W-1] ? (~d_w + 1'b1) : d_w;

   always_comb begin
      unique case (state_ff)
         DIVN, DIVD: begin
            sub_x = {rem_ff, quo_ff[W-1]};
            sub_y = {1'b0, b_ff};
         end
         default: begin
            sub_x = {1'b0, a_ff};
            sub_y = {1'b0, b_ff};
         end
      endcase
   end

   assign sub_diff   = sub_x - sub_y;
   assign sub_borrow = sub_diff[W];
   assign quo_shift  = {quo_ff[W-2:0], !sub_borrow};
   assign num_signed = neg_ff ? (~nq_ff + 1'b1) : nq_ff;

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      nq_in        = nq_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      res_num_in   = res_num_ff;
      res_den_in   = res_den_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_st_in    = rsp_st_ff;

      unique case (state_ff)
         IDLE: begin
            if (req_fire) begin
               res_num_in = '0;
               res_den_in = '0;
               res_st_in  = frg_pkg::ST_OK;
               priority if (d_w == '0) begin
                  res_st_in = frg_pkg::ST_ZERO_DEN;
                  state_in  = DONE;
               end else if (n_w == '0) begin
                  res_den_in = frg_pkg::DEN_BITS'(1);
                  state_in   = DONE;
               end else if (d_w[W-1] && (n_w == most_neg || d_w == most_neg)) begin
                  res_st_in = frg_pkg::ST_OVERFLOW;
                  state_in  = DONE;
               end else begin
                  neg_in   = n_w[W-1] ^ d_w[W-1];
                  num_in   = n_mag;
                  den_in   = d_mag;
                  a_in     = n_mag;
                  b_in     = d_mag;
                  k_in     = '0;
                  state_in = TWOS;
               end
            end
         end
         TWOS: begin
            // strip common factors of two
            if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end else begin
               state_in = GCD;
            end
         end
         GCD: begin
            priority if (a_ff == '0) begin
               state_in = SCALE;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (sub_borrow) begin
               // keep the larger value in a
               a_in = b_ff;
               b_in = a_ff;
            end else begin
               a_in = sub_diff[W-1:0] >> 1;
            end
         end
         SCALE: begin
            if (k_ff != '0) begin
               b_in = b_ff << 1;
               k_in = k_ff - 1'b1;
            end else begin
               rem_in   = '0;
               quo_in   = num_ff;
               cnt_in   = CNT_BITS'(W - 1);
               state_in = DIVN;
            end
         end
         DIVN: begin
            rem_in = sub_borrow ? sub_x[W-1:0] : sub_diff[W-1:0];
            quo_in = quo_shift;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               nq_in    = quo_shift;
               rem_in   = '0;
               quo_in   = den_ff;
               cnt_in   = CNT_BITS'(W - 1);
               state_in = DIVD;
            end
         end
         DIVD: begin
            rem_in = sub_borrow ? sub_x[W-1:0] : sub_diff[W-1:0];
            quo_in = quo_shift;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               res_num_in = frg_pkg::NUM_BITS'($signed(num_signed));
               res_den_in = frg_pkg::DEN_BITS'(quo_shift);
               res_st_in  = frg_pkg::ST_OK;
               state_in   = DONE;
            end
         end
         DONE: begin
            // hand over once the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = res_num_ff;
               rsp_den_in   = res_den_ff;
               rsp_st_in    = res_st_ff;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff       <= a_in;
      b_ff       <= b_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      nq_ff      <= nq_in;
      k_ff       <= k_in;
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      res_st_ff  <= res_st_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign rsp_port.valid               = rsp_valid_ff;
   assign rsp_port.reduced_numerator   = rsp_num_ff;
   assign rsp_port.reduced_denominator = rsp_den_ff;
   assign rsp_port.status              = rsp_st_ff;

   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == GCD && a_ff == '0) |-> (b_ff != '0))
      else $error("gcd finished with a zero divisor");

   a_err_den_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_st_ff != frg_pkg::ST_OK) |-> (rsp_den_ff == '0))
      else $error("error response with nonzero denominator");

   a_ok_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_st_ff == frg_pkg::ST_OK) |-> (rsp_den_ff != '0))
      else $error("ok response with zero denominator");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_port.ready)
      else $error("request taken while busy");

endmodule
